@@ rtl/sbus_receiver_with_takeover_macros.svh @@
// assertion macros shared by the sbus checker
`ifndef SBUS_RECEIVER_WITH_TAKEOVER_MACROS_SVH
`define SBUS_RECEIVER_WITH_TAKEOVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBUS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SBUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sbus_pkg.sv @@
// shared types and constants of the sbus receiver
package sbus_pkg;

  // frame layout
  localparam int FRAME_BYTES = 25;
  localparam int FS_BYTE     = 23;
  localparam int FS_BIT      = 3;
  localparam int CHAN_W      = 11;
  localparam int BYTE_IDX_W  = 5;
  localparam int OUT_CHANNELS = 5;
  localparam int STOP_CHAN   = 4;

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE = 8'h00;
  localparam logic [BYTE_IDX_W-1:0] LAST_INDEX = BYTE_IDX_W'(FRAME_BYTES - 1);

  // age counter
  localparam int AGE_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // configuration registers
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = CFG_INDEX_W'(1);
  localparam logic [AGE_W-1:0]  TIMEOUT_RESET   = AGE_W'(500);
  localparam logic [CHAN_W-1:0] THRESHOLD_RESET = CHAN_W'(400);

  // status of one step of the frame assembler
  typedef struct packed {
    logic done;
    logic good;
    logic sig_valid;
  } frame_stat_t;

endpackage

@@ rtl/sbus_frame_asm.sv @@
// sbus frame assembler: header hunt, byte collection and channel unpack
module sbus_frame_asm
  import sbus_pkg::*;
#(
  parameter int DECODED_CHANNELS = 5
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    step,
  input  logic                                    cmd,
  input  logic [7:0]                              rx_byte,
  output frame_stat_t                             stat,
  output logic [DECODED_CHANNELS-1:0][CHAN_W-1:0] chan_next
);

  localparam int PAYLOAD_BITS  = DECODED_CHANNELS * CHAN_W;
  localparam int PAYLOAD_BYTES = (PAYLOAD_BITS + 7) / 8;

  logic [BYTE_IDX_W-1:0] byte_index;
  logic [BYTE_IDX_W-1:0] byte_index_next;
  logic [7:0]            frame_store [FRAME_BYTES-1];
  logic [DECODED_CHANNELS-1:0][CHAN_W-1:0] channel_store;
  logic                  signal_valid;
  logic                  signal_valid_next;
  logic [PAYLOAD_BYTES*8-1:0] payload;
  logic                  hunting;
  logic                  take_byte;
  logic                  last;
  logic                  good;

  // byte classification
  assign hunting   = (byte_index == '0) && (rx_byte != HDR_BYTE);
  assign take_byte = !cmd && !hunting;
  assign last      = take_byte && (byte_index == LAST_INDEX);
  assign good      = last && (frame_store[0] == HDR_BYTE) && (rx_byte == END_BYTE);

  always_comb begin
    byte_index_next = byte_index;
    if (last) begin
      byte_index_next = '0;
    end else if (take_byte) begin
      byte_index_next = byte_index + 1'b1;
    end
  end

  // channel bits start at byte 1, little-endian, lsb first
  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_payload
    assign payload[8*i +: 8] = frame_store[i+1];
  end

  for (genvar k = 0; k < DECODED_CHANNELS; k++) begin : g_chan
    assign chan_next[k] = good ? payload[CHAN_W*k +: CHAN_W] : channel_store[k];
  end

  // failsafe frame clears signal valid
  assign signal_valid_next = good ? !frame_store[FS_BYTE][FS_BIT] : signal_valid;

  assign stat.done      = last;
  assign stat.good      = good;
  assign stat.sig_valid = signal_valid_next;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      channel_store <= '0;
      signal_valid  <= 1'b0;
    end else if (step) begin
      byte_index    <= byte_index_next;
      channel_store <= chan_next;
      signal_valid  <= signal_valid_next;
    end
  end

  // frame bytes, end byte is checked straight from the input
  always_ff @(posedge clk) begin
    if (step && take_byte && !last) begin
      frame_store[byte_index] <= rx_byte;
    end
  end

endmodule

@@ rtl/sbus_receiver_with_takeover.sv @@
// sbus receiver top level: request pipeline, age counter, takeover decision
// Takes one request per clock while in_stall is low (a received uart byte
// or a millisecond tick) and returns exactly one result per request, held
// in the input register, then passed through the frame decoder and
// takeover logic into the result register. A full result register that is
// stalled still lets one more request into the input register. Frames are
// 25 bytes starting with 0x0F; a frame ending in 0x00 updates channels,
// the failsafe state and restarts the tick age. Configuration writes
// (timeout_ticks, stop_threshold) are always ready and must only be issued
// while no request is in flight. No clearing pass is needed after reset.
module sbus_receiver_with_takeover
  import sbus_pkg::*;
#(
  parameter int DECODED_CHANNELS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [7:0]             rx_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   frame_done,
  output logic                   frame_good,
  output logic                   failsafe,
  output logic                   takeover,
  output logic                   emergency,
  output logic [CHAN_W-1:0]      chan0,
  output logic [CHAN_W-1:0]      chan1,
  output logic [CHAN_W-1:0]      chan2,
  output logic [CHAN_W-1:0]      chan3,
  output logic [CHAN_W-1:0]      chan4,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                 s1_valid;
  logic                 s1_cmd;
  logic [7:0]           s1_byte;
  logic                 advance;
  logic                 step;
  logic [AGE_W-1:0]     timeout_ticks;
  logic [CHAN_W-1:0]    stop_threshold;
  logic [AGE_W-1:0]     frame_age;
  logic [AGE_W-1:0]     frame_age_next;
  frame_stat_t          stat;
  logic [DECODED_CHANNELS-1:0][CHAN_W-1:0] chan_next;
  logic [OUT_CHANNELS-1:0][CHAN_W-1:0]     chan_all;
  logic                 take_next;
  logic                 emer_next;
  logic [OUT_CHANNELS-1:0][CHAN_W-1:0]     chan_q;

  // pipeline flow control
  assign advance  = !out_valid || !out_stall;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd  <= cmd;
      s1_byte <= rx_byte;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= TIMEOUT_RESET;
      stop_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT:   timeout_ticks  <= cfg_data[AGE_W-1:0];
        CFG_THRESHOLD: stop_threshold <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  sbus_frame_asm #(
    .DECODED_CHANNELS(DECODED_CHANNELS)
  ) u_asm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cmd       (s1_cmd),
    .rx_byte   (s1_byte),
    .stat      (stat),
    .chan_next (chan_next)
  );

  // saturating age since last good frame
  always_comb begin
    frame_age_next = frame_age;
    if (s1_cmd) begin
      if (frame_age != AGE_MAX) begin
        frame_age_next = frame_age + 1'b1;
      end
    end else if (stat.good) begin
      frame_age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_age <= AGE_MAX;
    end else if (step) begin
      frame_age <= frame_age_next;
    end
  end

  // channels past the decoded count read as zero
  for (genvar k = 0; k < OUT_CHANNELS; k++) begin : g_out_chan
    if (k < DECODED_CHANNELS) begin : g_dec
      assign chan_all[k] = chan_next[k];
    end else begin : g_zero
      assign chan_all[k] = '0;
    end
  end

  // takeover and emergency decision
  assign take_next = stat.sig_valid && (frame_age_next < timeout_ticks);
  assign emer_next = take_next && (chan_all[STOP_CHAN] < stop_threshold);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_done <= stat.done;
      frame_good <= stat.good;
      failsafe   <= !stat.sig_valid;
      takeover   <= take_next;
      emergency  <= emer_next;
      chan_q     <= chan_all;
    end
  end

  assign chan0 = chan_q[0];
  assign chan1 = chan_q[1];
  assign chan2 = chan_q[2];
  assign chan3 = chan_q[3];
  assign chan4 = chan_q[4];

endmodule

@@ rtl/sbus_checker.sv @@
// port-level checks of the sbus receiver and their binding
`include "sbus_receiver_with_takeover_macros.svh"

module sbus_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic frame_done,
  input logic frame_good,
  input logic failsafe,
  input logic takeover,
  input logic emergency
);

  // a stalled result stays offered
  `SBUS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a good frame is always a completed frame
  `SBUS_ASSERT_NOW(a_good_done, out_valid && frame_good, frame_done, "good frame not done")

  // emergency stop only under takeover
  `SBUS_ASSERT_NOW(a_emer_take, out_valid && emergency, takeover, "emergency without takeover")

  // takeover needs a valid signal
  `SBUS_ASSERT_NOW(a_take_valid, out_valid && takeover, !failsafe, "takeover during failsafe")

endmodule

bind sbus_receiver_with_takeover sbus_checker u_sbus_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_done (frame_done),
  .frame_good (frame_good),
  .failsafe   (failsafe),
  .takeover   (takeover),
  .emergency  (emergency)
);
